>>> src/qrab_pkg.sv
// Shared types, constants and the character map of the QR alphanumeric encoder.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package qrab_pkg;

  localparam int COUNT_BITS_DEF = 9;
  localparam int MAX_RESULTS    = 61;
  localparam int ALNUM_RADIX    = 45;

  localparam int CHAR_W  = 8;
  localparam int VAL_W   = 6;
  localparam int CHUNK_W = 11;
  localparam int WIDTH_W = 4;
  localparam int LEN_W   = 9;
  localparam int CAP_W   = 6;
  localparam int BITS_W  = 12;
  localparam int PAD_W   = 6;

  localparam logic [CHUNK_W-1:0] MODE_ALNUM = 11'd2;
  localparam logic [WIDTH_W-1:0] MODE_W     = 4'd4;
  localparam logic [WIDTH_W-1:0] PAIR_W     = 4'd11;
  localparam logic [WIDTH_W-1:0] SINGLE_W   = 4'd6;
  localparam logic [WIDTH_W-1:0] PAD_BYTE_W = 4'd8;
  localparam logic [CHUNK_W-1:0] PAD_FIRST  = 11'h0EC;
  localparam logic [CHUNK_W-1:0] PAD_SECOND = 11'h011;

  localparam logic REG_MESSAGE_LENGTH = 1'b0;
  localparam logic REG_CAPACITY       = 1'b1;

  typedef struct packed {
    logic               hdr;
    logic [CHUNK_W-1:0] cnt_val;
    logic               pair_vld;
    logic [CHUNK_W-1:0] pair_val;
    logic               tail_vld;
    logic [VAL_W-1:0]   tail_val;
    logic [PAD_W-1:0]   pad_cnt;
    logic               done;
  } qrab_job_t;

  function automatic logic [VAL_W-1:0] char_value(input logic [CHAR_W-1:0] c);
    logic [VAL_W-1:0] v;
    v = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = VAL_W'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      v = VAL_W'(c - 8'h41 + 8'd10);
    end else begin
      case (c)
        8'h20:   v = 6'd36;
        8'h24:   v = 6'd37;
        8'h25:   v = 6'd38;
        8'h2A:   v = 6'd39;
        8'h2B:   v = 6'd40;
        8'h2D:   v = 6'd41;
        8'h2E:   v = 6'd42;
        8'h2F:   v = 6'd43;
        8'h3A:   v = 6'd44;
        default: v = 6'd0;
      endcase
    end
    return v;
  endfunction

endpackage
`default_nettype wire

>>> src/qrab_cfg_regs.sv
// APB-style configuration registers of the QR alphanumeric encoder.
// Depends on qrab_pkg for widths and register indexes.
`default_nettype none
module qrab_cfg_regs
  import qrab_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output logic      [LEN_W-1:0] message_length,
  output logic      [CAP_W-1:0] capacity_codewords
);

  logic [LEN_W-1:0] message_length_r;
  logic [CAP_W-1:0] capacity_r;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      message_length_r <= LEN_W'(1);
      capacity_r       <= CAP_W'(19);
    end else if (wr_en) begin
      case (paddr[2])
        REG_MESSAGE_LENGTH: message_length_r <= pwdata[LEN_W-1:0];
        REG_CAPACITY:       capacity_r       <= pwdata[CAP_W-1:0];
        default:            message_length_r <= message_length_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_MESSAGE_LENGTH: prdata = {{(32-LEN_W){1'b0}}, message_length_r};
      REG_CAPACITY:       prdata = {{(32-CAP_W){1'b0}}, capacity_r};
      default:            prdata = '0;
    endcase
  end

  assign message_length     = message_length_r;
  assign capacity_codewords = capacity_r;

endmodule
`default_nettype wire

>>> src/qrab_emitter.sv
// Chunk emitter: holds the chunk plan of one character and sends its chunks,
// one per cycle while out_stall does not hold them, through the result register. Depends on qrab_pkg.
`default_nettype none
module qrab_emitter
  import qrab_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire qrab_job_t          job,
  output logic                    hold,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [CHUNK_W-1:0] out_chunk_value,
  output logic      [WIDTH_W-1:0] out_chunk_width,
  output logic                    out_last_of_run,
  output logic                    out_message_done
);

  qrab_job_t        job_r;
  logic             hdr_p_r, cnt_p_r, pair_p_r, tail_p_r, pad_odd_r;
  logic             hdr_p_nxt, cnt_p_nxt, pair_p_nxt, tail_p_nxt, pad_odd_nxt;
  logic [PAD_W-1:0] pad_left_r, pad_left_nxt;
  logic             job_vld, out_free, issue, last;
  logic [CHUNK_W-1:0] sel_val;
  logic [WIDTH_W-1:0] sel_w;

  logic               out_vld_r;
  logic [CHUNK_W-1:0] out_val_r;
  logic [WIDTH_W-1:0] out_w_r;
  logic               out_last_r, out_done_r;

  assign job_vld  = hdr_p_r || cnt_p_r || pair_p_r || tail_p_r || (pad_left_r != '0);
  assign out_free = !out_vld_r || !out_stall;
  assign issue    = job_vld && out_free;

  always_comb begin
    hdr_p_nxt    = hdr_p_r;
    cnt_p_nxt    = cnt_p_r;
    pair_p_nxt   = pair_p_r;
    tail_p_nxt   = tail_p_r;
    pad_left_nxt = pad_left_r;
    pad_odd_nxt  = pad_odd_r;
    if (hdr_p_r) begin
      sel_val   = MODE_ALNUM;
      sel_w     = MODE_W;
      hdr_p_nxt = 1'b0;
    end else if (cnt_p_r) begin
      sel_val   = job_r.cnt_val;
      sel_w     = WIDTH_W'(COUNT_BITS);
      cnt_p_nxt = 1'b0;
    end else if (pair_p_r) begin
      sel_val    = job_r.pair_val;
      sel_w      = PAIR_W;
      pair_p_nxt = 1'b0;
    end else if (tail_p_r) begin
      sel_val    = {{(CHUNK_W-VAL_W){1'b0}}, job_r.tail_val};
      sel_w      = SINGLE_W;
      tail_p_nxt = 1'b0;
    end else begin
      sel_val      = pad_odd_r ? PAD_FIRST : PAD_SECOND;
      sel_w        = PAD_BYTE_W;
      pad_left_nxt = pad_left_r - PAD_W'(1);
      pad_odd_nxt  = !pad_odd_r;
    end
    last = !(hdr_p_nxt || cnt_p_nxt || pair_p_nxt || tail_p_nxt || (pad_left_nxt != '0));
  end

  assign hold = job_vld && !(issue && last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_p_r    <= 1'b0;
      cnt_p_r    <= 1'b0;
      pair_p_r   <= 1'b0;
      tail_p_r   <= 1'b0;
      pad_left_r <= '0;
      pad_odd_r  <= 1'b1;
    end else if (load) begin
      hdr_p_r    <= job.hdr;
      cnt_p_r    <= job.hdr;
      pair_p_r   <= job.pair_vld;
      tail_p_r   <= job.tail_vld;
      pad_left_r <= job.pad_cnt;
      pad_odd_r  <= 1'b1;
    end else if (issue) begin
      hdr_p_r    <= hdr_p_nxt;
      cnt_p_r    <= cnt_p_nxt;
      pair_p_r   <= pair_p_nxt;
      tail_p_r   <= tail_p_nxt;
      pad_left_r <= pad_left_nxt;
      pad_odd_r  <= pad_odd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_val_r  <= sel_val;
      out_w_r    <= sel_w;
      out_last_r <= last;
      out_done_r <= last && job_r.done;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_chunk_value  = out_val_r;
  assign out_chunk_width  = out_w_r;
  assign out_last_of_run  = out_last_r;
  assign out_message_done = out_done_r;

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_done_r |-> out_last_r)
    else $error("Message end flagged on a chunk that does not end its run.");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !hold)
    else $error("Chunk plan loaded over a plan that still has chunks to send.");

  a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    job_vld && !out_free |=> job_vld)
    else $error("Chunk plan drained while the result register was stalled.");

endmodule
`default_nettype wire

>>> src/qr_alphanumeric_bitstream_encoder.sv
// QR alphanumeric-mode bitstream encoder, one character per transfer.
// Each character's chunk plan is built combinationally and loaded as it is taken; its chunks
// pass from the emitter's plan registers through the result register, one per cycle while
// out_stall is low. The input stalls until the last of a character's 0 to 61 chunks issues.
// Reset is synchronous and active low; it clears message state and restores the registers.
`default_nettype none
module qr_alphanumeric_bitstream_encoder
  import qrab_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [CHAR_W-1:0]  in_char_code,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [CHUNK_W-1:0] out_chunk_value,
  output logic      [WIDTH_W-1:0] out_chunk_width,
  output logic                    out_last_of_run,
  output logic                    out_message_done
);

  logic [LEN_W-1:0]  message_length;
  logic [CAP_W-1:0]  capacity_codewords;

  logic [LEN_W-1:0]  chars_seen_r, chars_seen_nxt;
  logic [VAL_W-1:0]  held_r, held_nxt;
  logic              holding_r, holding_nxt;
  logic [BITS_W-1:0] bits_r, bits_nxt;

  logic              accept, first, msg_end, load;
  logic [VAL_W-1:0]  v;
  logic [LEN_W-1:0]  cs_inc;
  logic [BITS_W-1:0] bw0, bw1, bw2;
  logic [LEN_W-1:0]  used, cap_ext;
  logic [2:0]        n_chunks;
  logic [PAD_W-1:0]  pads_raw, pads_lim;
  qrab_job_t         job;
  logic              hold;

  qrab_cfg_regs u_cfg (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .message_length     (message_length),
    .capacity_codewords (capacity_codewords)
  );

  assign in_stall = hold;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    v       = char_value(in_char_code);
    first   = (chars_seen_r == '0);
    cs_inc  = chars_seen_r + LEN_W'(1);
    msg_end = (cs_inc == message_length);
    bw0     = bits_r + (first ? BITS_W'(4 + COUNT_BITS) : BITS_W'(0));

    job          = '0;
    job.hdr      = first;
    job.cnt_val  = {{(CHUNK_W-LEN_W){1'b0}}, message_length};
    job.pair_vld = holding_r;
    job.pair_val = CHUNK_W'(held_r) * CHUNK_W'(ALNUM_RADIX) + CHUNK_W'(v);
    job.tail_val = v;
    job.tail_vld = msg_end && !holding_r;
    job.done     = msg_end;

    bw1     = bw0 + (holding_r ? BITS_W'(11) : BITS_W'(0));
    bw2     = bw1 + (job.tail_vld ? BITS_W'(6) : BITS_W'(0));
    used    = bw2[BITS_W-1:3];
    cap_ext = {{(LEN_W-CAP_W){1'b0}}, capacity_codewords};
    pads_raw = (cap_ext > used) ? PAD_W'(cap_ext - used) : '0;
    n_chunks = (first ? 3'd2 : 3'd0) + {2'b0, holding_r} + {2'b0, job.tail_vld};
    pads_lim = PAD_W'(7'(MAX_RESULTS) - {4'b0, n_chunks});
    job.pad_cnt = !msg_end ? '0 : ((pads_raw > pads_lim) ? pads_lim : pads_raw);

    load = accept && (first || holding_r || msg_end);

    if (msg_end) begin
      chars_seen_nxt = '0;
      held_nxt       = '0;
      holding_nxt    = 1'b0;
      bits_nxt       = '0;
    end else begin
      chars_seen_nxt = cs_inc;
      held_nxt       = holding_r ? VAL_W'(0) : v;
      holding_nxt    = !holding_r;
      bits_nxt       = bw1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_seen_r <= '0;
      held_r       <= '0;
      holding_r    <= 1'b0;
      bits_r       <= '0;
    end else if (accept) begin
      chars_seen_r <= chars_seen_nxt;
      held_r       <= held_nxt;
      holding_r    <= holding_nxt;
      bits_r       <= bits_nxt;
    end
  end

  qrab_emitter #(
    .COUNT_BITS (COUNT_BITS)
  ) u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (load),
    .job              (job),
    .hold             (hold),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_chunk_value  (out_chunk_value),
    .out_chunk_width  (out_chunk_width),
    .out_last_of_run  (out_last_of_run),
    .out_message_done (out_message_done)
  );

  a_hold_parity: assert property (@(posedge clk) disable iff (!rst_n)
    holding_r == chars_seen_r[0])
    else $error("Held character does not match the parity of the character count.");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && msg_end |=> chars_seen_r == '0 && !holding_r && bits_r == '0)
    else $error("Message state not cleared after the final character.");

  a_first_loads: assert property (@(posedge clk) disable iff (!rst_n)
    accept && first |-> load)
    else $error("First character of a message did not start a chunk run.");

endmodule
`default_nettype wire
